@@ hdl/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg: shared types and constants of the look-at view matrix block
// Fixed-point formats, the job and result records passed between the front,
// core and output stages, and the state encodings of the sequencers.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

	localparam int IN_FRAC_BITS  = 8;
	localparam int OUT_FRAC_BITS = 16;
	localparam int NORM_BITS     = 24;

	localparam int COORD_W = 16;                        // Q7.8 input coordinate
	localparam int DIFF_W  = COORD_W + 1;               // eye - target
	localparam int UVEC_W  = OUT_FRAC_BITS + 2;         // normalized component
	localparam int OPND_W  = UVEC_W;                    // multiplier operand
	localparam int PROD_W  = 2 * OPND_W;
	localparam int ACC_W   = PROD_W + 1;                // cross and dot sums
	localparam int SQ_W    = 2 * NORM_BITS;
	localparam int LEN2_W  = SQ_W + 2;
	localparam int ROOT_W  = LEN2_W / 2;
	localparam int QUO_W   = OUT_FRAC_BITS + 1;
	localparam int NUM_W   = NORM_BITS + OUT_FRAC_BITS + 1;
	localparam int ELEM_W  = 32;
	localparam int IN_DATA_W  = 9 * COORD_W;
	localparam int OUT_DATA_W = 136;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [UVEC_W-1:0]  uvec_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	typedef struct packed {
		coord_t [2:0] eye;
		diff_t  [2:0] d;
		coord_t [2:0] up;
	} job_t;

	typedef struct packed {
		uvec_t [2:0] u;
		uvec_t [2:0] v;
		uvec_t [2:0] n;
		acc_t  [2:0] t;     // dot products of each row with the eye point
		logic        deg;
	} res_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHIFT,
		N_SQ,
		N_SQRT,
		N_DLOAD,
		N_DIV,
		N_DONE
	} norm_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_NORM_D,
		C_CROSS_U,
		C_NORM_U,
		C_CROSS_V,
		C_NORM_V,
		C_DOT,
		C_LOAD
	} core_state_t;

endpackage

`default_nettype wire

@@ hdl/lav_front.sv @@
// ----------------------------------------------------------------------------
// lav_front: input stage
// Accepts input transactions, forms eye - target and holds the jobs in a
// two-entry queue until the core takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [lav_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                               job_valid,
	input  wire logic                          job_ready,
	output lav_pkg::job_t                      job
);

	lav_pkg::job_t    ent_q [2];
	logic             wptr_q, rptr_q;
	logic [1:0]       cnt_q;
	lav_pkg::job_t    new_job;
	logic             push, pop;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			new_job.eye[i] = s_tdata[lav_pkg::COORD_W*i +: lav_pkg::COORD_W];
			new_job.up[i]  = s_tdata[lav_pkg::COORD_W*(6+i) +: lav_pkg::COORD_W];
			new_job.d[i]   = lav_pkg::DIFF_W'(
				$signed(s_tdata[lav_pkg::COORD_W*i +: lav_pkg::COORD_W]))
				- lav_pkg::DIFF_W'(
				$signed(s_tdata[lav_pkg::COORD_W*(3+i) +: lav_pkg::COORD_W]));
		end
	end

	assign s_tready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = ent_q[rptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

@@ hdl/lav_norm.sv @@
// ----------------------------------------------------------------------------
// lav_norm: iterative vector normalizer
// Scales the magnitudes so the largest has 24 significant bits, sums the
// squares on one multiplier, takes a bit-pair square root and divides each
// component by the length with a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire lav_pkg::acc_t c [3],
	output logic               done,
	output lav_pkg::uvec_t     o [3],
	output logic               zero
);

	localparam int MAG_W = lav_pkg::ACC_W;
	localparam int NB    = lav_pkg::NORM_BITS;

	lav_pkg::norm_state_t state_q, state_d;

	logic [MAG_W-1:0]            m_q [3];
	logic [MAG_W-1:0]            big_q;
	logic                        neg_q [3];
	logic [1:0]                  cnt_q;
	logic [4:0]                  it_q;
	logic [lav_pkg::SQ_W-1:0]    sq_s1;
	logic [lav_pkg::LEN2_W-1:0]  len2_q, x_q;
	logic [lav_pkg::ROOT_W-1:0]  root_q;
	logic [lav_pkg::ROOT_W+1:0]  srem_q;
	logic [lav_pkg::ROOT_W:0]    drem_q;
	logic [lav_pkg::QUO_W-1:0]   rnum_q, quo_q;
	lav_pkg::uvec_t              o_q [3];
	logic                        zero_q;

	logic [MAG_W-1:0]            mag [3];
	logic [MAG_W-1:0]            big;
	logic [lav_pkg::ROOT_W+2:0]  rem2, trial;
	logic [lav_pkg::ROOT_W:0]    drem2;
	logic                        qbit;
	logic [lav_pkg::QUO_W-1:0]   quo_n;
	logic [lav_pkg::NUM_W-1:0]   num;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = c[i][MAG_W-1] ? MAG_W'(0) - MAG_W'(c[i]) : MAG_W'(c[i]);
		end
		big = mag[0];
		if (mag[1] > big) big = mag[1];
		if (mag[2] > big) big = mag[2];
		rem2  = {srem_q[lav_pkg::ROOT_W:0], x_q[lav_pkg::LEN2_W-1 -: 2]};
		trial = {1'b0, root_q, 2'b01};
		drem2 = {drem_q[lav_pkg::ROOT_W-1:0], rnum_q[lav_pkg::QUO_W-1]};
		qbit  = (drem2 >= {1'b0, root_q});
		quo_n = {quo_q[lav_pkg::QUO_W-2:0], qbit};
		num   = lav_pkg::NUM_W'({m_q[cnt_q][NB-1:0], lav_pkg::OUT_FRAC_BITS'(0)})
			+ lav_pkg::NUM_W'(root_q >> 1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lav_pkg::N_IDLE: begin
				if (start) state_d = (big == '0) ? lav_pkg::N_DONE : lav_pkg::N_SHIFT;
			end
			lav_pkg::N_SHIFT: begin
				if (big_q[MAG_W-1:NB] == '0 && big_q[NB-1]) state_d = lav_pkg::N_SQ;
			end
			lav_pkg::N_SQ: begin
				if (cnt_q == 2'd3) state_d = lav_pkg::N_SQRT;
			end
			lav_pkg::N_SQRT: begin
				if (it_q == 5'(lav_pkg::ROOT_W - 1)) state_d = lav_pkg::N_DLOAD;
			end
			lav_pkg::N_DLOAD: state_d = lav_pkg::N_DIV;
			lav_pkg::N_DIV: begin
				if (it_q == 5'(lav_pkg::QUO_W - 1)) begin
					state_d = (cnt_q == 2'd2) ? lav_pkg::N_DONE : lav_pkg::N_DLOAD;
				end
			end
			lav_pkg::N_DONE: state_d = lav_pkg::N_IDLE;
			default: state_d = lav_pkg::N_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		done = (state_q == lav_pkg::N_DONE);
		zero = zero_q;
		for (int i = 0; i < 3; i++) o[i] = o_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lav_pkg::N_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lav_pkg::N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						m_q[i]   <= mag[i];
						neg_q[i] <= c[i][MAG_W-1];
						o_q[i]   <= '0;
					end
					big_q  <= big;
					zero_q <= (big == '0);
				end
			end
			lav_pkg::N_SHIFT: begin
				// One bit a cycle; a right shift truncates just as one wide shift would.
				if (big_q[MAG_W-1:NB] != '0) begin
					big_q <= big_q >> 1;
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end else if (!big_q[NB-1]) begin
					big_q <= big_q << 1;
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end else begin
					cnt_q  <= 2'd0;
					len2_q <= '0;
				end
			end
			lav_pkg::N_SQ: begin
				if (cnt_q != 2'd3) begin
					sq_s1 <= m_q[cnt_q][NB-1:0] * m_q[cnt_q][NB-1:0];
				end
				if (cnt_q != 2'd0) len2_q <= len2_q + lav_pkg::LEN2_W'(sq_s1);
				if (cnt_q == 2'd3) begin
					x_q    <= len2_q + lav_pkg::LEN2_W'(sq_s1);
					root_q <= '0;
					srem_q <= '0;
					it_q   <= '0;
				end
				cnt_q <= cnt_q + 2'd1;
			end
			lav_pkg::N_SQRT: begin
				if (rem2 >= trial) begin
					srem_q <= (lav_pkg::ROOT_W+2)'(rem2 - trial);
					root_q <= {root_q[lav_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					srem_q <= rem2[lav_pkg::ROOT_W+1:0];
					root_q <= {root_q[lav_pkg::ROOT_W-2:0], 1'b0};
				end
				x_q   <= x_q << 2;
				it_q  <= it_q + 5'd1;
				cnt_q <= 2'd0;
			end
			lav_pkg::N_DLOAD: begin
				drem_q <= (lav_pkg::ROOT_W+1)'(num[lav_pkg::NUM_W-1:lav_pkg::QUO_W]);
				rnum_q <= num[lav_pkg::QUO_W-1:0];
				quo_q  <= '0;
				it_q   <= '0;
			end
			lav_pkg::N_DIV: begin
				drem_q <= qbit ? drem2 - {1'b0, root_q} : drem2;
				rnum_q <= rnum_q << 1;
				quo_q  <= quo_n;
				it_q   <= it_q + 5'd1;
				if (it_q == 5'(lav_pkg::QUO_W - 1)) begin
					o_q[cnt_q] <= neg_q[cnt_q] ? lav_pkg::UVEC_W'(0) - lav_pkg::UVEC_W'(quo_n)
					                           : lav_pkg::UVEC_W'(quo_n);
					cnt_q <= cnt_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/lav_core.sv @@
// ----------------------------------------------------------------------------
// lav_core: back-end sequencer
// Takes one job from the front queue and works through normalize, cross
// product and dot product steps on a shared multiplier and the normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire lav_pkg::job_t job,
	output logic               res_valid,
	input  wire logic          res_ready,
	output lav_pkg::res_t      res
);

	lav_pkg::core_state_t state_q, state_d;

	lav_pkg::coord_t eye_q [3];
	lav_pkg::coord_t up_q  [3];
	lav_pkg::diff_t  d_q   [3];
	lav_pkg::uvec_t  n_q [3], u_q [3], v_q [3];
	lav_pkg::acc_t   cr_q [3], t_q [3];
	logic            deg_q;
	logic            norm_run_q;
	logic [1:0]      grp_q, sub_q;
	logic            iss_done_q;

	logic signed [lav_pkg::PROD_W-1:0] prod_s1;
	logic            mvld_s1, mfirst_s1, mstore_s1, msub_s1;
	logic [1:0]      mgrp_s1;
	lav_pkg::acc_t   acc_q, sum;

	logic            norm_go, norm_done, norm_zero;
	lav_pkg::acc_t   norm_in [3];
	lav_pkg::uvec_t  norm_out [3];
	logic            mac_state, is_dot, last_sub, issue;
	logic [1:0]      ja, kb;
	logic signed [lav_pkg::OPND_W-1:0] opa, opb;
	lav_pkg::uvec_t  rowv [3];

	function automatic logic [1:0] cross_j(input logic [1:0] g);
		case (g)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] cross_k(input logic [1:0] g);
		case (g)
			2'd0:    return 2'd2;
			2'd1:    return 2'd0;
			default: return 2'd1;
		endcase
	endfunction

	lav_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_go),
		.c      (norm_in),
		.done   (norm_done),
		.o      (norm_out),
		.zero   (norm_zero)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lav_pkg::C_IDLE:    if (job_valid) state_d = lav_pkg::C_NORM_D;
			lav_pkg::C_NORM_D:  if (norm_done) state_d = lav_pkg::C_CROSS_U;
			lav_pkg::C_CROSS_U: if (iss_done_q && !mvld_s1) state_d = lav_pkg::C_NORM_U;
			lav_pkg::C_NORM_U:  if (norm_done) state_d = lav_pkg::C_CROSS_V;
			lav_pkg::C_CROSS_V: if (iss_done_q && !mvld_s1) state_d = lav_pkg::C_NORM_V;
			lav_pkg::C_NORM_V:  if (norm_done) state_d = lav_pkg::C_DOT;
			lav_pkg::C_DOT:     if (iss_done_q && !mvld_s1) state_d = lav_pkg::C_LOAD;
			lav_pkg::C_LOAD:    if (res_ready) state_d = lav_pkg::C_IDLE;
			default:            state_d = lav_pkg::C_IDLE;
		endcase
	end

	// Outputs and operand selection.
	always_comb begin
		job_ready = (state_q == lav_pkg::C_IDLE);
		res_valid = (state_q == lav_pkg::C_LOAD);
		norm_go   = !norm_run_q && (state_q == lav_pkg::C_NORM_D ||
			state_q == lav_pkg::C_NORM_U || state_q == lav_pkg::C_NORM_V);
		for (int i = 0; i < 3; i++) begin
			norm_in[i] = (state_q == lav_pkg::C_NORM_D) ? lav_pkg::ACC_W'(d_q[i]) : cr_q[i];
			res.u[i] = u_q[i];
			res.v[i] = v_q[i];
			res.n[i] = n_q[i];
			res.t[i] = t_q[i];
		end
		res.deg = deg_q;
		rowv = u_q;
		case (grp_q)
			2'd0:    rowv = u_q;
			2'd1:    rowv = v_q;
			default: rowv = n_q;
		endcase
		is_dot    = (state_q == lav_pkg::C_DOT);
		mac_state = is_dot || state_q == lav_pkg::C_CROSS_U || state_q == lav_pkg::C_CROSS_V;
		last_sub  = is_dot ? (sub_q == 2'd2) : (sub_q == 2'd1);
		issue     = mac_state && !iss_done_q;
		ja = (sub_q == 2'd0) ? cross_j(grp_q) : cross_k(grp_q);
		kb = (sub_q == 2'd0) ? cross_k(grp_q) : cross_j(grp_q);
		if (is_dot) begin
			opa = rowv[sub_q];
			opb = lav_pkg::OPND_W'(eye_q[sub_q]);
		end else if (state_q == lav_pkg::C_CROSS_U) begin
			opa = lav_pkg::OPND_W'(up_q[ja]);
			opb = lav_pkg::OPND_W'(d_q[kb]);
		end else begin
			opa = n_q[ja];
			opb = u_q[kb];
		end
		if (mfirst_s1) sum = lav_pkg::ACC_W'(prod_s1);
		else if (msub_s1) sum = acc_q - lav_pkg::ACC_W'(prod_s1);
		else sum = acc_q + lav_pkg::ACC_W'(prod_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lav_pkg::C_IDLE;
			norm_run_q <= 1'b0;
			grp_q      <= 2'd0;
			sub_q      <= 2'd0;
			iss_done_q <= 1'b0;
			mvld_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (norm_go) norm_run_q <= 1'b1;
			else if (norm_done) norm_run_q <= 1'b0;
			mvld_s1 <= issue;
			if (issue) begin
				if (last_sub) begin
					sub_q <= 2'd0;
					grp_q <= grp_q + 2'd1;
					if (grp_q == 2'd2) iss_done_q <= 1'b1;
				end else begin
					sub_q <= sub_q + 2'd1;
				end
			end else if (!mac_state) begin
				grp_q      <= 2'd0;
				sub_q      <= 2'd0;
				iss_done_q <= 1'b0;
			end else if (!mvld_s1) begin
				grp_q      <= 2'd0;
				iss_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			for (int i = 0; i < 3; i++) begin
				eye_q[i] <= job.eye[i];
				up_q[i]  <= job.up[i];
				d_q[i]   <= job.d[i];
			end
			deg_q <= 1'b0;
		end else if (norm_done) begin
			deg_q <= deg_q | norm_zero;
		end
		if (norm_done) begin
			case (state_q)
				lav_pkg::C_NORM_D: n_q <= norm_out;
				lav_pkg::C_NORM_U: u_q <= norm_out;
				default:           v_q <= norm_out;
			endcase
		end
		if (issue) begin
			prod_s1   <= opa * opb;
			mfirst_s1 <= (sub_q == 2'd0);
			mstore_s1 <= last_sub;
			msub_s1   <= !is_dot;
			mgrp_s1   <= grp_q;
		end
		if (mvld_s1) begin
			acc_q <= sum;
			if (mstore_s1) begin
				if (is_dot) t_q[mgrp_s1] <= sum;
				else cr_q[mgrp_s1] <= sum;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/lav_out.sv @@
// ----------------------------------------------------------------------------
// lav_out: result bank and row emitter
// Holds one finished matrix, rounds and saturates the translations, and
// sends the four rows one transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_out (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire lav_pkg::res_t res,
	output logic               free,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [1:0]         row_index,
	output logic [lav_pkg::ELEM_W-1:0] elem [4],
	output logic               degenerate,
	output logic               last_row
);

	localparam int EW = lav_pkg::ELEM_W;

	logic                full_q;
	logic [1:0]          row_q;
	lav_pkg::uvec_t      rot_q [3][3];
	logic [EW-1:0]       tr_q [3];
	logic                deg_q;

	function automatic logic [EW-1:0] round_sat(input lav_pkg::acc_t s);
		logic signed [lav_pkg::ACC_W:0] t;
		logic [lav_pkg::ACC_W:0]        mg, mr;
		t  = -(lav_pkg::ACC_W+1)'(s);
		mg = t[lav_pkg::ACC_W] ? (lav_pkg::ACC_W+1)'(0) - t : t;
		mr = (mg + (lav_pkg::ACC_W+1)'(1 << (lav_pkg::IN_FRAC_BITS - 1)))
			>> lav_pkg::IN_FRAC_BITS;
		if (t[lav_pkg::ACC_W]) begin
			if (mr > (lav_pkg::ACC_W+1)'(64'h8000_0000)) return {1'b1, (EW-1)'(0)};
			return EW'(0) - mr[EW-1:0];
		end
		if (mr > (lav_pkg::ACC_W+1)'(64'h7FFF_FFFF)) return {1'b0, {(EW-1){1'b1}}};
		return mr[EW-1:0];
	endfunction

	assign free       = !full_q;
	assign m_tvalid   = full_q;
	assign row_index  = row_q;
	assign degenerate = deg_q;
	assign last_row   = (row_q == 2'd3);

	always_comb begin
		for (int i = 0; i < 4; i++) elem[i] = '0;
		if (row_q == 2'd3) begin
			elem[3] = EW'(1) << lav_pkg::OUT_FRAC_BITS;
		end else if (!deg_q) begin
			for (int i = 0; i < 3; i++) elem[i] = EW'(rot_q[row_q][i]);
			elem[3] = tr_q[row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			row_q  <= 2'd0;
		end else if (load && !full_q) begin
			full_q <= 1'b1;
			row_q  <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			row_q <= row_q + 2'd1;
			if (row_q == 2'd3) full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !full_q) begin
			for (int i = 0; i < 3; i++) begin
				rot_q[0][i] <= res.u[i];
				rot_q[1][i] <= res.v[i];
				rot_q[2][i] <= res.n[i];
				tr_q[i]     <= round_sat(res.t[i]);
			end
			deg_q <= res.deg;
		end
	end

endmodule

`default_nettype wire

@@ hdl/look_at_view_matrix.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix: fixed-point look-at view matrix
// Builds the four rows of a view matrix from an eye point, a target point and
// an up direction.
//
//   Channel  Dir  Fields (tdata from bit 0 up)                    Extra
//   s_*      in   eye_x..z, target_x..z, upvec_x..z (16 b each)   -
//   m_*      out  row_index, elem0..elem3 (32 b each), pad        tuser=degenerate,
//                                                                 tlast=last_row
//
// In the core an item goes through three normalizations, each a shift search,
// the squares, 25 square root steps and three divisions, plus three multiply
// runs; a vector of zero length skips its search, squares, root and divisions.
// The iterative normalizer takes most of the time. A two-entry queue in front
// and a one-matrix output bank let input and output stall independently of the
// core. Reset clears control state except the normalizer counters, set before
// use; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
	input  wire logic [lav_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// row_index, elem0, elem1, elem2, elem3, zero pad
	output logic [lav_pkg::OUT_DATA_W-1:0]      m_tdata,
	// degenerate
	output logic                                m_tuser,
	output logic                                m_tlast
);

	logic                          job_valid, job_ready;
	lav_pkg::job_t                 job;
	logic                          res_valid, res_free;
	lav_pkg::res_t                 res;
	logic [1:0]                    row_index;
	logic [lav_pkg::ELEM_W-1:0]    elem [4];

	lav_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	lav_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.res_valid (res_valid),
		.res_ready (res_free),
		.res       (res)
	);

	lav_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (res_valid),
		.res        (res),
		.free       (res_free),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.row_index  (row_index),
		.elem       (elem),
		.degenerate (m_tuser),
		.last_row   (m_tlast)
	);

	assign m_tdata = {6'b0, elem[3], elem[2], elem[1], elem[0], row_index};

	// A matrix is never cut short: a row other than the last is followed by more.
	a_rows_continue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("output bank emptied before the last row");

	// Row numbers step by one within a matrix.
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1)
		else $error("row index out of order");

	// A degenerate matrix carries zeros in its rotation and translation rows.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && !m_tlast |-> m_tdata[129:2] == '0)
		else $error("degenerate row is not zero");

	// Only the fourth row is marked last.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
		else $error("last marker on the wrong row");

endmodule

`default_nettype wire
